// ===== rtl/core/lmsaf_pkg.sv =====
`default_nettype none

package lmsaf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 24;
  localparam int MUL_A_W  = 33;
  localparam int MUL_P_W  = MUL_A_W + SAMPLE_W;
  localparam int WIDE_W   = 48;

  localparam logic [15:0] STEP_SIZE_RESET = 16'd13107;

  localparam logic signed [WIDE_W-1:0] S16_MAX = 48'sd32767;
  localparam logic signed [WIDE_W-1:0] S16_MIN = -48'sd32768;
  localparam logic signed [WIDE_W-1:0] W_MAX   = 48'sd8388607;
  localparam logic signed [WIDE_W-1:0] W_MIN   = -48'sd8388608;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;

  function automatic sample_t sat16(input logic signed [WIDE_W-1:0] v);
    sample_t r;
    if (v > S16_MAX) begin
      r = S16_MAX[SAMPLE_W-1:0];
    end else if (v < S16_MIN) begin
      r = S16_MIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic weight_t sat24(input logic signed [WIDE_W-1:0] v);
    weight_t r;
    if (v > W_MAX) begin
      r = W_MAX[WEIGHT_W-1:0];
    end else if (v < W_MIN) begin
      r = W_MIN[WEIGHT_W-1:0];
    end else begin
      r = v[WEIGHT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lms_adaptive_fir.sv =====
`default_nettype none

// LMS adaptive FIR filter, Q1.15 samples and Q4.20 weights. One word in gives
// one word out: the filter output (pre-update weights) and the error, both
// saturated to 16 bits. A single 33x16 multiplier does all the arithmetic and
// passes over the taps twice per word (once for the FIR sum, once for the
// weight update), so the input takes no new word until the last one has
// reached the output register; in_ready is high only between words. The result waits in an
// output register, so a new word may be taken while it is still pending; if
// it is still held when the next result is ready, the final step waits for it.
// Weights and delay line clear at reset; step_size resets to 0.2. The user
// must write it through cfg_write/cfg_data only while idle; the block itself
// does not enforce this.
module lms_adaptive_fir #(
  parameter int NUM_TAPS = 5
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_write,
  input  wire [15:0]             cfg_data,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire signed [15:0]      reference_sample,
  input  wire signed [15:0]      desired_sample,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic signed [15:0]     filter_output,
  output logic signed [15:0]     error_value
);

  localparam int CNT_W = $clog2(NUM_TAPS + 1);
  localparam int ACC_W = lmsaf_pkg::SAMPLE_W + lmsaf_pkg::WEIGHT_W + CNT_W;
  localparam int Y_W   = ACC_W - 20;
  localparam int P_W   = lmsaf_pkg::MUL_P_W;
  localparam int D_W   = P_W - 26;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_ROUND,
    S_ERR,
    S_MU,
    S_UPD,
    S_DONE
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;
  logic [15:0] step_size;
  lmsaf_pkg::sample_t tap_line [NUM_TAPS];
  lmsaf_pkg::weight_t tap_weights [NUM_TAPS];
  lmsaf_pkg::sample_t des;
  lmsaf_pkg::sample_t y_sat;
  lmsaf_pkg::sample_t err;
  logic signed [ACC_W-1:0] acc;
  logic signed [Y_W-1:0] y;
  logic signed [lmsaf_pkg::MUL_A_W-1:0] mu_e;
  logic signed [P_W-1:0] prod;

  logic signed [lmsaf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [lmsaf_pkg::SAMPLE_W-1:0] mul_b;
  logic signed [P_W-1:0] mul_out;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [P_W-1:0] prod_rnd;
  logic signed [D_W-1:0] delta;
  lmsaf_pkg::weight_t w_upd;

  assign in_ready = (state == S_IDLE);

  // shared multiplier
  always_comb begin
    case (state)
      S_MU: begin
        mul_a = lmsaf_pkg::MUL_A_W'($signed({1'b0, step_size}));
        mul_b = err;
      end
      S_UPD: begin
        mul_a = mu_e;
        mul_b = tap_line[0];
      end
      default: begin
        mul_a = lmsaf_pkg::MUL_A_W'(tap_weights[0]);
        mul_b = tap_line[0];
      end
    endcase
    mul_out = P_W'(mul_a) * P_W'(mul_b);
  end

  always_comb begin
    acc_rnd  = acc + (ACC_W'(1) <<< 19);
    prod_rnd = prod + (P_W'(1) <<< 25);
    delta    = prod_rnd[P_W-1:26];
    w_upd    = lmsaf_pkg::sat24(lmsaf_pkg::WIDE_W'(tap_weights[0])
                                + lmsaf_pkg::WIDE_W'(delta));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      step_size <= lmsaf_pkg::STEP_SIZE_RESET;
      out_valid <= 1'b0;
      acc       <= '0;
      for (int k = 0; k < NUM_TAPS; k++) begin
        tap_line[k]    <= '0;
        tap_weights[k] <= '0;
      end
    end else begin
      if (cfg_write) begin
        step_size <= cfg_data;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tap_line[0] <= reference_sample;
            for (int k = 1; k < NUM_TAPS; k++) begin
              tap_line[k] <= tap_line[k-1];
            end
            des   <= desired_sample;
            acc   <= '0;
            cnt   <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (cnt < CNT_W'(NUM_TAPS)) begin
            prod <= mul_out;
            for (int k = 0; k < NUM_TAPS - 1; k++) begin
              tap_line[k]    <= tap_line[k+1];
              tap_weights[k] <= tap_weights[k+1];
            end
            tap_line[NUM_TAPS-1]    <= tap_line[0];
            tap_weights[NUM_TAPS-1] <= tap_weights[0];
          end
          if (cnt != '0) begin
            acc <= acc + ACC_W'(prod);
          end
          if (cnt == CNT_W'(NUM_TAPS)) begin
            state <= S_ROUND;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ROUND: begin
          y     <= acc_rnd[ACC_W-1:20];
          state <= S_ERR;
        end
        S_ERR: begin
          y_sat <= lmsaf_pkg::sat16(lmsaf_pkg::WIDE_W'(y));
          err   <= lmsaf_pkg::sat16(lmsaf_pkg::WIDE_W'(des) - lmsaf_pkg::WIDE_W'(y));
          state <= S_MU;
        end
        S_MU: begin
          mu_e  <= mul_out[lmsaf_pkg::MUL_A_W-1:0];
          cnt   <= '0;
          state <= S_UPD;
        end
        S_UPD: begin
          if (cnt < CNT_W'(NUM_TAPS)) begin
            prod <= mul_out;
            for (int k = 0; k < NUM_TAPS - 1; k++) begin
              tap_line[k] <= tap_line[k+1];
            end
            tap_line[NUM_TAPS-1] <= tap_line[0];
          end
          // weights shift in the cycle after the taps, once the product is registered
          if (cnt != '0) begin
            for (int k = 0; k < NUM_TAPS - 1; k++) begin
              tap_weights[k] <= tap_weights[k+1];
            end
            tap_weights[NUM_TAPS-1] <= w_upd;
          end
          if (cnt == CNT_W'(NUM_TAPS)) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            filter_output <= y_sat;
            error_value   <= err;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_mac: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MAC && acc == '0 && cnt == '0))
    else $error("accepted word did not start the sum");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(NUM_TAPS))
    else $error("tap counter past the last tap");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the final step");

  a_mac_to_round: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC && cnt == CNT_W'(NUM_TAPS)) |=> state == S_ROUND)
    else $error("sum did not end after the last tap");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_lms_adaptive_fir.sv =====
`default_nettype none

module tb_lms_adaptive_fir;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTAPS = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    lmsaf_pkg::sample_t x;
    lmsaf_pkg::sample_t d;
  } sample_pair_t;

  typedef struct packed {
    lmsaf_pkg::sample_t y;
    lmsaf_pkg::sample_t e;
  } fir_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  lmsaf_pkg::sample_t reference_sample = '0;
  lmsaf_pkg::sample_t desired_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lmsaf_pkg::sample_t filter_output;
  lmsaf_pkg::sample_t error_value;

  sample_pair_t pairs_to_send[$];
  fir_result_t outputs_due[$];

  // predictor state
  logic [15:0] step_q = lmsaf_pkg::STEP_SIZE_RESET;
  lmsaf_pkg::sample_t x_line[NTAPS];
  lmsaf_pkg::weight_t lms_weights[NTAPS];

  // stimulus plant for system identification runs
  lmsaf_pkg::sample_t plant_coef[NTAPS];
  lmsaf_pkg::sample_t plant_hist[NTAPS];

  int mismatches = 0;
  int words_in = 0;
  int cycles = 0;
  int hold_left = 0;
  int holds_done = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_mode = 0;
  int rx_left = 0;

  always #1 clk = ~clk;

  lms_adaptive_fir #(
    .NUM_TAPS(NTAPS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .reference_sample(reference_sample),
    .desired_sample(desired_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .filter_output(filter_output),
    .error_value(error_value)
  );

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void lms_predict(input lmsaf_pkg::sample_t x,
                                      input lmsaf_pkg::sample_t d);
    longint acc;
    longint y;
    longint err;
    longint mu_e;
    longint w;
    fir_result_t r;
    for (int k = NTAPS - 1; k > 0; k--) x_line[k] = x_line[k-1];
    x_line[0] = x;
    acc = 0;
    for (int k = 0; k < NTAPS; k++) begin
      acc += longint'(lms_weights[k]) * longint'(x_line[k]);
    end
    y = (acc + longint'(524288)) >>> 20;
    err = clip(longint'(d) - y, -32768, 32767);
    mu_e = longint'(step_q) * err;
    for (int k = 0; k < NTAPS; k++) begin
      w = longint'(lms_weights[k]) +
          ((mu_e * longint'(x_line[k]) + longint'(33554432)) >>> 26);
      lms_weights[k] = lmsaf_pkg::weight_t'(clip(w, -8388608, 8388607));
    end
    r.y = lmsaf_pkg::sample_t'(clip(y, -32768, 32767));
    r.e = lmsaf_pkg::sample_t'(err);
    outputs_due.push_back(r);
  endfunction

  function automatic lmsaf_pkg::sample_t edge_value();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  task automatic queue_pair(input lmsaf_pkg::sample_t x, input lmsaf_pkg::sample_t d);
    sample_pair_t p;
    p.x = x;
    p.d = d;
    pairs_to_send.push_back(p);
  endtask

  task automatic queue_random(input int n);
    int left;
    int mode;
    int amp_sh;
    longint acc;
    lmsaf_pkg::sample_t x;
    lmsaf_pkg::sample_t d;
    left = 0;
    mode = 0;
    amp_sh = 0;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        left = $urandom_range(8, 60);
        mode = $urandom_range(0, 19);
        amp_sh = $urandom_range(0, 6);
        for (int k = 0; k < NTAPS; k++) begin
          plant_coef[k] = lmsaf_pkg::sample_t'($urandom) >>> 2;
        end
      end
      left--;
      if (mode < 12) begin
        x = lmsaf_pkg::sample_t'($urandom) >>> amp_sh;
        for (int k = NTAPS - 1; k > 0; k--) plant_hist[k] = plant_hist[k-1];
        plant_hist[0] = x;
        acc = 0;
        for (int k = 0; k < NTAPS; k++) begin
          acc += longint'(plant_coef[k]) * longint'(plant_hist[k]);
        end
        acc = (acc >>> 15) + longint'($urandom_range(0, 64)) - 32;
        d = lmsaf_pkg::sample_t'(clip(acc, -32768, 32767));
      end else if (mode < 17) begin
        x = lmsaf_pkg::sample_t'($urandom);
        d = lmsaf_pkg::sample_t'($urandom);
      end else begin
        x = edge_value();
        d = edge_value();
      end
      queue_pair(x, d);
    end
  endtask

  task automatic set_step(input logic [15:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    step_q = v;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pairs_to_send.size() != 0 || in_valid || outputs_due.size() != 0);
  endtask

  // sender
  always @(posedge clk) begin
    logic fire;
    sample_pair_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        lms_predict(reference_sample, desired_sample);
        words_in <= words_in + 1;
      end
      if (!in_valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pairs_to_send.size() != 0) begin
          nxt = pairs_to_send.pop_front();
          in_valid <= 1'b1;
          reference_sample <= nxt.x;
          desired_sample <= nxt.d;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                   : $urandom_range(0, 4);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-offs while the sender keeps offering words
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && words_in >= 150) ||
                 (holds_done == 1 && words_in >= 1300)) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    fir_result_t want;
    logic rdy;
    if (rst) begin
      out_ready <= 1'b0;
      rx_mode = 0;
      rx_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (outputs_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected word: y=%0d e=%0d", filter_output, error_value);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = outputs_due.pop_front();
          if (filter_output !== want.y || error_value !== want.e) begin
            if (mismatches < 10) begin
              $display("mismatch: y exp %0d got %0d, e exp %0d got %0d",
                       want.y, filter_output, want.e, error_value);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(50, 400);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      out_ready <= rdy && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < NTAPS; k++) begin
      x_line[k] = '0;
      lms_weights[k] = '0;
      plant_hist[k] = '0;
      plant_coef[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset step size
    queue_pair(0, 0);
    queue_pair(32767, 32767);
    queue_pair(32767, 32767);
    queue_pair(-32768, -32768);
    queue_pair(-32768, 32767);
    queue_pair(32767, -32768);
    queue_pair(1, -1);
    queue_pair(-1, 1);
    queue_pair(0, 32767);
    queue_pair(0, -32768);
    queue_pair(16384, -16384);
    queue_pair(0, 0);
    queue_random(300);
    wait_drained();

    // full step, drives weights, output and error into saturation
    set_step(16'hFFFF);
    for (int i = 0; i < 8; i++) queue_pair(32767, -32768);
    for (int i = 0; i < 4; i++) queue_pair(-32768, 32767);
    queue_random(250);
    wait_drained();

    set_step(16'h0000);
    queue_random(150);
    wait_drained();

    set_step(16'h0001);
    queue_random(150);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      set_step(16'((p % 2 == 0) ? $urandom_range(0, 65535)
                                : $urandom_range(200, 8000)));
      queue_random(180);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && outputs_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/lmsaf_pkg.sv
rtl/core/lms_adaptive_fir.sv
tb/tb_lms_adaptive_fir.sv
